>>> design/flbm_pkg.sv
// Package for the landmark blink and mouth classifier.
// Holds shared widths, the back-end job struct and the sequencer state type.
package flbm_pkg;
  localparam int CoordBits = 13;
  localparam int SeenBits  = 7;
  localparam int NumSlots  = 15;
  localparam int SlotBits  = 4;
  localparam int SqBits    = 2 * CoordBits + 2;   // squared distance width
  localparam int RootIn    = SqBits + 16;         // squared distance shifted for Q8
  localparam int RootBits  = RootIn / 2;
  localparam int MouthBits = 14;
  localparam int EarBits   = 16;

  localparam logic [SeenBits-1:0] SeenMax   = 7'd127;
  localparam logic [SeenBits-1:0] LeftNeed  = 7'd42;
  localparam logic [SeenBits-1:0] RightNeed = 7'd48;
  localparam logic [SeenBits-1:0] MouthNeed = 7'd58;
  localparam logic [SeenBits-1:0] NoseNeed  = 7'd29;

  localparam int CfgEar   = 0;
  localparam int CfgMouth = 1;

  typedef struct packed {
    logic [SeenBits-1:0] count;
    logic                fit;
  } job_t;

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_ROOT, S_ACC, S_DONE
  } state_t;

  // slot of a landmark index, NumSlots when not kept
  function automatic logic [SlotBits-1:0] slot_of(input logic [SeenBits-1:0] idx);
    logic [SlotBits-1:0] s;
    s = SlotBits'(NumSlots);
    if (idx == 7'd28) s = 4'd0;
    else if (idx >= 7'd36 && idx < 7'd48) s = SlotBits'(idx - 7'd35);
    else if (idx == 7'd51) s = 4'd13;
    else if (idx == 7'd57) s = 4'd14;
    return s;
  endfunction
endpackage

>>> design/flbm_front.sv
// Front end: counts points, stores kept landmarks, posts a job on the last point.
// Depends on flbm_pkg. Kept-point store is read by the back end through one port.
module flbm_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [flbm_pkg::CoordBits-1:0] in_x,
  input  logic signed [flbm_pkg::CoordBits-1:0] in_y,
  input  logic                                in_fit,
  input  logic                                in_last,
  output logic                                job_valid,
  input  logic                                job_ready,
  input  logic                                store_free,
  output flbm_pkg::job_t                      job,
  input  logic [flbm_pkg::SlotBits-1:0]       rd_slot,
  output logic [2*flbm_pkg::CoordBits-1:0]    rd_data
);
  logic [2*flbm_pkg::CoordBits-1:0] store [flbm_pkg::NumSlots];
  logic [flbm_pkg::SeenBits-1:0] seen;
  logic [flbm_pkg::SeenBits-1:0] cnt;
  logic [flbm_pkg::SlotBits-1:0] slot;
  logic                          acc;
  // one-deep job queue; the store is shared, so hold input while a job is pending
  // or the back end still reads kept points
  logic                          busy;

  assign in_ready = !busy && store_free;
  assign acc      = in_valid && in_ready;
  assign slot     = flbm_pkg::slot_of(seen);
  assign cnt      = (seen < flbm_pkg::SeenMax) ? seen + 7'd1 : seen;

  always_ff @(posedge clk) begin
    if (acc && seen < flbm_pkg::SeenMax && slot < flbm_pkg::SlotBits'(flbm_pkg::NumSlots))
      store[slot] <= {in_y, in_x};
    rd_data <= store[rd_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
      busy <= 1'b0;
    end else begin
      if (acc) seen <= in_last ? '0 : cnt;
      if (acc && in_last) busy <= 1'b1;
      else if (job_ready && busy) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_last) begin
      job <= flbm_pkg::job_t'{count: cnt, fit: in_fit};
    end
  end
  assign job_valid = busy;
endmodule

>>> design/flbm_sqrt.sv
// Bit-serial integer square root, one result bit (two radicand bits) per cycle.
// Depends on flbm_pkg for widths.
module flbm_sqrt (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [flbm_pkg::RootIn-1:0]      radicand,
  output logic                             done,
  output logic [flbm_pkg::RootBits-1:0]    root
);
  localparam int W = flbm_pkg::RootIn;
  localparam int IterBits = $clog2(flbm_pkg::RootBits + 1);
  logic [W-1:0] rem;
  logic [W-1:0] num;
  logic [flbm_pkg::RootBits-1:0] res;
  logic [IterBits-1:0] iter;
  logic         run;
  logic [W+1:0] trial;
  logic [W+1:0] rem_sh;

  assign rem_sh = {rem, num[W-1:W-2]};
  assign trial  = rem_sh - {res, 2'b01};
  assign root   = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        rem <= '0;
        res <= '0;
        num <= radicand;
        iter <= IterBits'(flbm_pkg::RootBits);
      end else if (run) begin
        num <= num << 2;
        if (!trial[W+1]) begin
          rem <= trial[W-1:0];
          res <= {res[flbm_pkg::RootBits-2:0], 1'b1};
        end else begin
          rem <= rem_sh[W-1:0];
          res <= {res[flbm_pkg::RootBits-2:0], 1'b0};
        end
        iter <= iter - 1'b1;
        if (iter == IterBits'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> design/flbm_back.sv
// Back end: sequences distance roots for both eyes and the lips, builds the result.
// Depends on flbm_pkg and flbm_sqrt.
module flbm_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                job_valid,
  output logic                                job_ready,
  output logic                                store_free,
  input  flbm_pkg::job_t                      job,
  output logic [flbm_pkg::SlotBits-1:0]       rd_slot,
  input  logic [2*flbm_pkg::CoordBits-1:0]    rd_data,
  input  logic [flbm_pkg::EarBits-1:0]        ear_thr,
  input  logic [flbm_pkg::MouthBits-1:0]      mouth_thr,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [7:0]                          out_flags,
  output logic [flbm_pkg::MouthBits-1:0]      out_mouth,
  output logic signed [flbm_pkg::CoordBits-1:0] out_nx,
  output logic signed [flbm_pkg::CoordBits-1:0] out_ny
);
  localparam int CB = flbm_pkg::CoordBits;
  localparam int RB = flbm_pkg::RootBits;
  localparam int EarW = flbm_pkg::EarBits;
  localparam int NumDist = 7;
  // distance pairs: left v1, v2, h; right v1, v2, h; lips
  function automatic logic [7:0] pair_of(input logic [2:0] k);
    logic [7:0] p;
    case (k)
      3'd0: p = {4'd2, 4'd6};
      3'd1: p = {4'd3, 4'd5};
      3'd2: p = {4'd1, 4'd4};
      3'd3: p = {4'd8, 4'd12};
      3'd4: p = {4'd9, 4'd11};
      3'd5: p = {4'd7, 4'd10};
      default: p = {4'd13, 4'd14};
    endcase
    return p;
  endfunction

  flbm_pkg::state_t state, state_next;
  flbm_pkg::job_t   cur;
  logic [2:0] k;
  logic [7:0] pr;
  logic [1:0] ld;
  logic signed [CB-1:0] ax, ay;
  logic signed [CB:0]   dx, dy;
  logic [CB:0]          ux, uy;
  logic [2*CB+1:0]      sq;
  logic                 sq_go, sq_done;
  logic [RB-1:0]        root;
  logic [RB:0]          vl, vr;
  logic [RB-1:0]        hl, hr;
  logic [flbm_pkg::SqBits-1:0] lip_sq;
  logic [RB+12:0]       lhs_l, lhs_r;
  logic [RB+EarW:0]     rhs_l, rhs_r;
  logic                 lb, rb_, mo;
  logic                 cmp_st;
  logic [2*flbm_pkg::MouthBits-1:0] mm;

  assign pr = pair_of(k);
  assign dx = {rd_data[CB-1], rd_data[CB-1:0]} - {ax[CB-1], ax};
  assign dy = {rd_data[2*CB-1], rd_data[2*CB-1:CB]} - {ay[CB-1], ay};

  flbm_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_go),
    .radicand(k == 3'd6 ? {16'd0, sq} : {sq, 16'd0}),
    .done(sq_done), .root(root)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      flbm_pkg::S_IDLE: if (job_valid) state_next = flbm_pkg::S_LOAD;
      flbm_pkg::S_LOAD: if (ld == 2'd3) state_next = flbm_pkg::S_ROOT;
      flbm_pkg::S_ROOT: if (sq_done) state_next = flbm_pkg::S_ACC;
      flbm_pkg::S_ACC:
        state_next = (k == 3'(NumDist - 1)) ? flbm_pkg::S_DONE : flbm_pkg::S_LOAD;
      flbm_pkg::S_DONE: if (out_ready && cmp_st) state_next = flbm_pkg::S_IDLE;
      default: state_next = flbm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    job_ready  = (state == flbm_pkg::S_IDLE);
    store_free = (state == flbm_pkg::S_IDLE) || ((state == flbm_pkg::S_DONE) && cmp_st);
    out_valid  = (state == flbm_pkg::S_DONE) && cmp_st;
    rd_slot    = (ld == 2'd0) ? pr[7:4] : pr[3:0];
    // point at the nose slot ahead of the result cycle
    if (state == flbm_pkg::S_ACC || state == flbm_pkg::S_DONE) rd_slot = 4'd0;
  end

  assign lhs_l = {vl, 12'd0};
  assign lhs_r = {vr, 12'd0};
  assign rhs_l = {hl, 1'b0} * ear_thr;
  assign rhs_r = {hr, 1'b0} * ear_thr;
  assign mm    = mouth_thr * mouth_thr;
  assign lb    = (cur.count >= flbm_pkg::LeftNeed) ?
                 ((RB+EarW+1)'(lhs_l) < rhs_l) : (ear_thr > 16'd4096);
  assign rb_   = (cur.count >= flbm_pkg::RightNeed) ?
                 ((RB+EarW+1)'(lhs_r) < rhs_r) : (ear_thr > 16'd4096);
  assign mo    = lip_sq > mm;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= flbm_pkg::S_IDLE;
      cmp_st <= 1'b0;
      sq_go <= 1'b0;
    end else begin
      state <= state_next;
      sq_go <= (state == flbm_pkg::S_LOAD) && (ld == 2'd3);
      if (state == flbm_pkg::S_IDLE) cmp_st <= 1'b0;
      else if (state == flbm_pkg::S_DONE) cmp_st <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == flbm_pkg::S_IDLE && job_valid) begin
      cur <= job; k <= '0; ld <= '0; vl <= '0; vr <= '0;
    end
    if (state == flbm_pkg::S_LOAD) begin
      ld <= ld + 2'd1;
      // read data is registered, so it follows the slot in the next cycle
      if (ld == 2'd1) begin
        ax <= rd_data[CB-1:0]; ay <= rd_data[2*CB-1:CB];
      end
      if (ld == 2'd2) begin
        ux <= dx[CB] ? -dx : dx;
        uy <= dy[CB] ? -dy : dy;
      end
      if (ld == 2'd3) sq <= ux * ux + uy * uy;
    end
    if (state == flbm_pkg::S_ROOT && sq_done) begin
      case (k) inside
        3'd0, 3'd1: vl <= vl + root;
        3'd2: hl <= root;
        3'd3, 3'd4: vr <= vr + root;
        3'd5: hr <= root;
        default: begin
          out_mouth <= (root > RB'(16383)) ? 14'h3fff : root[13:0];
          lip_sq    <= sq[flbm_pkg::SqBits-1:0];
        end
      endcase
    end
    if (state == flbm_pkg::S_ACC) begin
      k <= k + 3'd1; ld <= '0;
    end
    if (state == flbm_pkg::S_DONE && !cmp_st) begin
      out_flags <= {5'd0, cur.fit & (cur.count >= flbm_pkg::MouthNeed) & mo,
                    cur.fit & rb_, cur.fit & lb};
      if (!(cur.fit && cur.count >= flbm_pkg::MouthNeed)) out_mouth <= '0;
      if (cur.fit && cur.count >= flbm_pkg::NoseNeed) begin
        out_nx <= rd_data[CB-1:0]; out_ny <= rd_data[2*CB-1:CB];
      end else begin
        out_nx <= '0; out_ny <= '0;
      end
    end
  end
endmodule

>>> design/face_landmark_blink_mouth_classifier_unit.sv
// Top level of the landmark blink and mouth classifier.
// Depends on flbm_pkg, flbm_front, flbm_back, flbm_sqrt.
// Points are taken one per cycle while s_tready is high. On the last point of
// a face set the front end hands a job to the back end, which works out seven
// distances through one shared bit-serial square root; each distance fetches
// its points, runs the root and accumulates. Input is held from the last
// point until the result is offered; the next set may then stream in while
// that result waits, and after its own last point input is held until the
// back end has taken the job.
module face_landmark_blink_mouth_classifier_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,  // point_x[12:0], point_y[25:13], fit_ok[26], zero
  input  logic        s_tlast,  // last_point
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // left_blink, right_blink, mouth_distance[15:2],
                                // mouth_open[16], nose_x[29:17], nose_y[42:30], zero
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  logic [flbm_pkg::EarBits-1:0]   ear_thr;
  logic [flbm_pkg::MouthBits-1:0] mouth_thr;
  logic job_valid, job_ready;
  logic store_free;
  flbm_pkg::job_t job;
  logic [flbm_pkg::SlotBits-1:0] rd_slot;
  logic [25:0] rd_data;
  logic [7:0]  flags;
  logic [13:0] md;
  logic signed [12:0] nx, ny;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      ear_thr   <= 16'd819;
      mouth_thr <= 14'd20;
    end else if (cfg_valid) begin
      if (cfg_index == 1'(flbm_pkg::CfgEar)) ear_thr <= cfg_data;
      else mouth_thr <= cfg_data[13:0];
    end
  end

  flbm_front u_front (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .in_x(s_tdata[12:0]), .in_y(s_tdata[25:13]), .in_fit(s_tdata[26]),
    .in_last(s_tlast), .job_valid(job_valid), .job_ready(job_ready),
    .store_free(store_free), .job(job),
    .rd_slot(rd_slot), .rd_data(rd_data)
  );

  flbm_back u_back (
    .clk(clk), .rst(rst), .job_valid(job_valid), .job_ready(job_ready),
    .store_free(store_free), .job(job),
    .rd_slot(rd_slot), .rd_data(rd_data), .ear_thr(ear_thr), .mouth_thr(mouth_thr),
    .out_valid(m_tvalid), .out_ready(m_tready), .out_flags(flags),
    .out_mouth(md), .out_nx(nx), .out_ny(ny)
  );

  assign m_tdata = {5'd0, ny, nx, flags[2], md, flags[1], flags[0]};

`ifndef SYNTH
  a_job_held: assert property (@(posedge clk) disable iff (rst)
    job_valid && !job_ready |=> job_valid) else $error("job dropped");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
    job_valid |-> !s_tready) else $error("input taken while job pending");
`endif
endmodule

>>> sim/face_landmark_blink_mouth_classifier_unit_tb.sv
// Testbench for the landmark blink and mouth classifier: streams face sets,
// predicts each set's result and checks it field by field. Depends on flbm_pkg
// and the design files under design/.
module face_landmark_blink_mouth_classifier_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // lowest field last, to match the result bus from bit 0 up
  typedef struct packed {
    logic [flbm_pkg::CoordBits-1:0] nose_y;
    logic [flbm_pkg::CoordBits-1:0] nose_x;
    logic                           mouth_open;
    logic [flbm_pkg::MouthBits-1:0] mouth_distance;
    logic                           right_blink;
    logic                           left_blink;
  } face_res_t;

  typedef struct {
    int        x;
    int        y;
    bit        fit;
    bit        last;
    bit        typed;
    face_res_t res;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;  // point_x, point_y, fit_ok, zero
  logic        s_tlast = 1'b0;  // last_point
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [47:0] m_tdata;  // left_blink, right_blink, mouth_distance, mouth_open, nose_x, nose_y
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // flag set alongside an item whose result is typed in the table
  logic        item_typed = 1'b0;
  face_res_t   item_res = '0;

  face_landmark_blink_mouth_classifier_unit DUT (.*);

  always #10 clk = ~clk;

  // predictor state
  logic signed [flbm_pkg::CoordBits-1:0] slot_x [flbm_pkg::NumSlots];
  logic signed [flbm_pkg::CoordBits-1:0] slot_y [flbm_pkg::NumSlots];
  int unsigned seen_cnt = 0;
  int unsigned ear_thr = 819;
  int unsigned mouth_thr = 20;

  face_res_t   face_results_q[$];
  int          fail_cnt = 0;
  int          send_pct = 0;
  int          stall_pct = 0;
  stim_row_t   rows[23];

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned span_sq(int a, int b);
    longint dx, dy;
    dx = longint'(slot_x[a]) - longint'(slot_x[b]);
    dy = longint'(slot_y[a]) - longint'(slot_y[b]);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return longint'(dx * dx + dy * dy);
  endfunction

  function automatic logic eye_closed(int base, bit complete);
    longint unsigned vert, horiz;
    if (!complete) return 4096 < ear_thr;
    vert = root64(span_sq(base + 1, base + 5) << 16) + root64(span_sq(base + 2, base + 4) << 16);
    horiz = root64(span_sq(base, base + 3) << 16);
    return (vert * 4096) < (2 * horiz * ear_thr);
  endfunction

  // advance predictor by one point; returns 1 when the point closes a set
  function automatic bit classify_point(logic [31:0] d, logic lst, output face_res_t r);
    logic [flbm_pkg::SlotBits-1:0] s;
    int unsigned cnt;
    longint unsigned sq, lip_root;
    r = '0;
    if (seen_cnt < 127) begin
      s = flbm_pkg::slot_of(flbm_pkg::SeenBits'(seen_cnt));
      if (s < flbm_pkg::NumSlots) begin
        slot_x[s] = d[12:0];
        slot_y[s] = d[25:13];
      end
      seen_cnt++;
    end
    cnt = seen_cnt;
    if (!lst) return 0;
    seen_cnt = 0;
    if (!d[26]) return 1;
    r.left_blink = eye_closed(1, cnt >= 42);
    r.right_blink = eye_closed(7, cnt >= 48);
    if (cnt >= 58) begin
      sq = span_sq(13, 14);
      lip_root = root64(sq);
      r.mouth_distance = lip_root > 16383 ? 14'd16383 : flbm_pkg::MouthBits'(lip_root);
      r.mouth_open = sq > longint'(mouth_thr) * mouth_thr;
    end
    if (cnt >= 29) begin
      r.nose_x = slot_x[0];
      r.nose_y = slot_y[0];
    end
    return 1;
  endfunction

  always @(posedge clk) begin : accept_point
    face_res_t r;
    if (!rst && s_tvalid && s_tready) begin
      if (classify_point(s_tdata, s_tlast, r)) begin
        face_results_q.insert(face_results_q.size(), item_typed ? item_res : r);
      end
    end
  end

  always @(posedge clk) begin : check_result
    face_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[42:0];
      if (face_results_q.size() == 0) begin
        $error("result with none pending: %h", got);
        fail_cnt++;
      end else begin
        want = face_results_q.pop_front();
        if (got.left_blink !== want.left_blink) begin
          $error("left_blink exp %0d got %0d", want.left_blink, got.left_blink); fail_cnt++;
        end
        if (got.right_blink !== want.right_blink) begin
          $error("right_blink exp %0d got %0d", want.right_blink, got.right_blink); fail_cnt++;
        end
        if (got.mouth_distance !== want.mouth_distance) begin
          $error("mouth_distance exp %0d got %0d", want.mouth_distance, got.mouth_distance);
          fail_cnt++;
        end
        if (got.mouth_open !== want.mouth_open) begin
          $error("mouth_open exp %0d got %0d", want.mouth_open, got.mouth_open); fail_cnt++;
        end
        if (got.nose_x !== want.nose_x) begin
          $error("nose_x exp %h got %h", want.nose_x, got.nose_x); fail_cnt++;
        end
        if (got.nose_y !== want.nose_y) begin
          $error("nose_y exp %h got %h", want.nose_y, got.nose_y); fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  task automatic send_point(int x, int y, bit fit, bit lst, bit typed, face_res_t r);
    if ($urandom_range(0, 99) < send_pct) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'd0, fit, 13'(y), 13'(x)};
    s_tlast <= lst;
    item_typed <= typed;
    item_res <= r;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic write_reg(int idx, int val);
    s_tvalid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx[0:0];
    cfg_data <= 16'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == flbm_pkg::CfgEar) ear_thr = val & 16'hFFFF;
    else mouth_thr = val & 14'h3FFF;
  endtask

  task automatic settle;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (face_results_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  function automatic int near_coord(int c, int spread);
    int v;
    v = c + int'($urandom_range(0, 2 * spread)) - spread;
    if (v > 4095) v = 4095;
    if (v < -4096) v = -4096;
    return v;
  endfunction

  task automatic send_face_set(output int len);
    int spread, cx, cy;
    int pick;
    int gaps[8] = '{28, 29, 41, 42, 47, 48, 57, 58};
    pick = $urandom_range(0, 9);
    if (pick <= 5) len = 68;
    else if (pick == 6) len = gaps[$urandom_range(0, 7)];
    else if (pick == 7) len = $urandom_range(59, 90);
    else if (pick == 8) len = $urandom_range(128, 140);
    else len = $urandom_range(1, 4);
    case ($urandom_range(0, 2))
      0: spread = 3;
      1: spread = 40;
      default: spread = 8191;
    endcase
    cx = int'($urandom_range(0, 8191)) - 4096;
    cy = int'($urandom_range(0, 8191)) - 4096;
    for (int i = 0; i < len; i++) begin
      // last point carries the fit flag, mostly good; others carry noise
      send_point(near_coord(cx, spread), near_coord(cy, spread),
                 (i == len - 1) ? ($urandom_range(0, 9) != 0) : 1'($urandom_range(0, 1)),
                 i == len - 1, 1'b0, '0);
    end
  endtask

  initial begin
    #(20ns * 4000000);
    $display("face_landmark_blink_mouth_classifier_unit_tb: errors");
    $finish;
  end

  initial begin
    int items;
    int set_len;
    rows[0] = '{0, 0, 1'b0, 1'b1, 1'b1, '0};          // fit failed after reset
    rows[1] = '{4095, -4096, 1'b1, 1'b1, 1'b1, '0};   // single point, eyes default open
    rows[2] = '{-4096, 4095, 1'b1, 1'b1, 1'b1, '0};
    for (int i = 3; i < 23; i++)
      rows[i] = '{(i % 2) ? 4095 : -4096, (i % 3) ? -4096 : 4095, 1'b1, i == 22, 1'b0, '0};
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].fit, rows[i].last,
                                 rows[i].typed, rows[i].res);
    item_typed <= 1'b0;
    settle();
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(flbm_pkg::CfgEar, 819); write_reg(flbm_pkg::CfgMouth, 20); end
        1: begin write_reg(flbm_pkg::CfgEar, 0); write_reg(flbm_pkg::CfgMouth, 0); end
        2: begin write_reg(flbm_pkg::CfgEar, 65535); write_reg(flbm_pkg::CfgMouth, 11585); end
        3: begin write_reg(flbm_pkg::CfgEar, 4097); write_reg(flbm_pkg::CfgMouth, 1); end
        4: begin
          write_reg(flbm_pkg::CfgEar, 4096);
          write_reg(flbm_pkg::CfgMouth, $urandom_range(0, 11585));
        end
        default: begin
          write_reg(flbm_pkg::CfgEar, $urandom_range(300, 3000));
          write_reg(flbm_pkg::CfgMouth, $urandom_range(0, 100));
        end
      endcase
      case (ph % 4)
        0: begin send_pct = 0; stall_pct = 0; end
        1: begin send_pct = 62; stall_pct = 0; end
        2: begin send_pct = 0; stall_pct = 62; end
        default: begin send_pct = 11; stall_pct = 11; end
      endcase
      // at least 160 points per phase, more once the last set runs over
      items = 0;
      while (items < 160) begin
        send_face_set(set_len);
        items += set_len;
      end
      settle();
    end
    if (fail_cnt == 0) begin
      $display("face_landmark_blink_mouth_classifier_unit_tb: clean");
    end else begin
      $display("face_landmark_blink_mouth_classifier_unit_tb: errors");
    end
    $finish;
  end
endmodule
